### hw/rtl/pgks_pkg.sv
// Shared types, widths and constants for the Poisson Green kernel scaling block.
// Used by every module in hw/rtl; depends on nothing else.
package pgks_pkg;

    localparam int IDX_W  = 10;
    localparam int GRID_W = 11;
    localparam int STEP_W = 32;
    localparam int VAL_W  = 32;
    localparam int TERM_W = 64;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [GRID_W-1:0] MAX_GRID = GRID_W'(1024);

    localparam int MOD_STEPS    = GRID_W;
    localparam int ANG_STEPS    = 31;
    localparam int CORDIC_STEPS = 30;
    localparam int QUOT_STEPS   = 32;

    localparam int AXIS_LAT = 1 + MOD_STEPS + ANG_STEPS + 1 + CORDIC_STEPS + 5;
    localparam int QUOT_LAT = 1 + QUOT_STEPS + 1;

    localparam int          CORDIC_GAIN_Q30 = 652032874;
    localparam logic [31:0] INV_PI_Q32      = 32'd1367130551;
    localparam int          QUARTER_TURN    = 1073741824;

    localparam logic [29:0] ATAN_TURN [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1
    };

    localparam logic [2:0] REG_KERNEL_MODE = 3'd0;
    localparam logic [2:0] REG_DIMENSIONS  = 3'd1;
    localparam logic [2:0] REG_GRID_X      = 3'd2;
    localparam logic [2:0] REG_GRID_Y      = 3'd3;
    localparam logic [2:0] REG_GRID_Z      = 3'd4;
    localparam logic [2:0] REG_STEP_X      = 3'd5;
    localparam logic [2:0] REG_STEP_Y      = 3'd6;
    localparam logic [2:0] REG_STEP_Z      = 3'd7;

    typedef struct packed {
        logic [IDX_W-1:0]        wave_index_x;
        logic [IDX_W-1:0]        wave_index_y;
        logic [IDX_W-1:0]        wave_index_z;
        logic signed [VAL_W-1:0] value_real;
        logic signed [VAL_W-1:0] value_imag;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_real;
        logic signed [VAL_W-1:0] result_imag;
        logic                    saturated;
    } t_out;

    typedef struct packed {
        logic              kernel_mode;
        logic [1:0]        dimensions;
        logic [GRID_W-1:0] grid_size_x;
        logic [GRID_W-1:0] grid_size_y;
        logic [GRID_W-1:0] grid_size_z;
        logic [STEP_W-1:0] wave_step_x;
        logic [STEP_W-1:0] wave_step_y;
        logic [STEP_W-1:0] wave_step_z;
    } t_cfg;

    typedef struct packed {
        logic             zero_mode;
        logic             neg_real;
        logic             neg_imag;
        logic [VAL_W-1:0] mag_real;
        logic [VAL_W-1:0] mag_imag;
    } t_tag;

endpackage

### hw/rtl/pgks_regs.sv
// Configuration register file behind the APB-style port.
// Depends on pgks_pkg for the register layout and the configuration struct.
module pgks_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pgks_pkg::ADDR_W-1:0] paddr,
    input  logic [pgks_pkg::DATA_W-1:0] pwdata,
    output logic [pgks_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output pgks_pkg::t_cfg             o_cfg
);
    import pgks_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kernel_mode <= 1'b0;
            r_cfg.dimensions  <= 2'd3;
            r_cfg.grid_size_x <= MAX_GRID;
            r_cfg.grid_size_y <= MAX_GRID;
            r_cfg.grid_size_z <= MAX_GRID;
            r_cfg.wave_step_x <= STEP_W'(32'h0100_0000);
            r_cfg.wave_step_y <= STEP_W'(32'h0100_0000);
            r_cfg.wave_step_z <= STEP_W'(32'h0100_0000);
        end else if (wr_en) begin
            case (reg_idx)
                REG_KERNEL_MODE: r_cfg.kernel_mode <= pwdata[0];
                REG_DIMENSIONS:  r_cfg.dimensions  <= pwdata[1:0];
                REG_GRID_X:      r_cfg.grid_size_x <= pwdata[GRID_W-1:0];
                REG_GRID_Y:      r_cfg.grid_size_y <= pwdata[GRID_W-1:0];
                REG_GRID_Z:      r_cfg.grid_size_z <= pwdata[GRID_W-1:0];
                REG_STEP_X:      r_cfg.wave_step_x <= pwdata[STEP_W-1:0];
                REG_STEP_Y:      r_cfg.wave_step_y <= pwdata[STEP_W-1:0];
                REG_STEP_Z:      r_cfg.wave_step_z <= pwdata[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KERNEL_MODE: prdata = DATA_W'(r_cfg.kernel_mode);
            REG_DIMENSIONS:  prdata = DATA_W'(r_cfg.dimensions);
            REG_GRID_X:      prdata = DATA_W'(r_cfg.grid_size_x);
            REG_GRID_Y:      prdata = DATA_W'(r_cfg.grid_size_y);
            REG_GRID_Z:      prdata = DATA_W'(r_cfg.grid_size_z);
            REG_STEP_X:      prdata = DATA_W'(r_cfg.wave_step_x);
            REG_STEP_Y:      prdata = DATA_W'(r_cfg.wave_step_y);
            REG_STEP_Z:      prdata = DATA_W'(r_cfg.wave_step_z);
            default:         prdata = '0;
        endcase
    end

endmodule

### hw/rtl/pgks_axis_term.sv
// Pipelined Green coefficient term for one axis: index folding, bit-per-stage
// modulo and angle division, CORDIC sine, scaling and squaring. Uses pgks_pkg.
module pgks_axis_term (
    input  logic                        i_clk,
    input  logic                        i_adv,
    input  logic                        i_mode,
    input  logic [pgks_pkg::IDX_W-1:0]  i_idx,
    input  logic [pgks_pkg::GRID_W-1:0] i_grid,
    input  logic [pgks_pkg::STEP_W-1:0] i_step,
    output logic [pgks_pkg::TERM_W-1:0] o_term
);
    import pgks_pkg::*;

    localparam int DSH_W = GRID_W + MOD_STEPS - 1;
    localparam int CX_W  = 34;
    localparam int CZ_W  = 33;
    localparam int T_W   = 29;
    localparam int ND_W  = GRID_W + STEP_W;
    localparam int P_W   = 43;
    localparam int PL_W  = 22;
    localparam int PH_W  = P_W - PL_W;
    localparam int SQ_W  = 2 * P_W;

    localparam logic signed [CX_W-1:0] Y_MAX = CX_W'(QUARTER_TURN);

    logic [GRID_W-1:0] n;
    logic [GRID_W-1:0] idx_ext;
    logic [GRID_W-1:0] fold_mag;

    logic [GRID_W-1:0] r_mag;
    logic [GRID_W-1:0] r_mrem [MOD_STEPS];
    logic [GRID_W-1:0] r_mmag [MOD_STEPS];
    logic [GRID_W-1:0] r_arem [ANG_STEPS];
    logic [ANG_STEPS-1:0] r_aq [ANG_STEPS];
    logic [GRID_W-1:0] r_amag [ANG_STEPS];
    logic [ANG_STEPS-1:0] r_z;
    logic [GRID_W-1:0] r_zmag;
    logic signed [CX_W-1:0] r_cx [CORDIC_STEPS];
    logic signed [CX_W-1:0] r_cy [CORDIC_STEPS];
    logic signed [CZ_W-1:0] r_cz [CORDIC_STEPS];
    logic [GRID_W-1:0] r_cmag [CORDIC_STEPS];

    logic [ANG_STEPS-1:0] z_raw;
    logic signed [CX_W-1:0] y_last;
    logic [ANG_STEPS-1:0] s;
    logic [62:0] tprod;
    logic [T_W-1:0]  r_t;
    logic [ND_W-1:0] r_nd;
    logic [GRID_W-1:0] r_m1mag;
    logic [60:0] r_pplo;
    logic [39:0] r_pphi;
    logic [P_W-1:0] r_pc;
    logic [72:0] prod;
    logic [P_W-1:0] r_p;
    logic [2*PH_W-1:0] r_hh;
    logic [PH_W+PL_W-1:0] r_hl;
    logic [2*PL_W-1:0] r_ll;
    logic [SQ_W-1:0] sq;
    logic [TERM_W-1:0] r_term;

    always_comb begin
        if (i_grid == '0) begin
            n = GRID_W'(1);
        end else if (i_grid > MAX_GRID) begin
            n = MAX_GRID;
        end else begin
            n = i_grid;
        end
    end

    assign idx_ext = GRID_W'(i_idx);

    always_comb begin
        if ({idx_ext, 1'b0} > {1'b0, n}) begin
            fold_mag = (idx_ext < n) ? (n - idx_ext) : (idx_ext - n);
        end else begin
            fold_mag = idx_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mag <= fold_mag;
        end
    end

    for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
        localparam int B = MOD_STEPS - 1 - k;
        logic [GRID_W-1:0] rem_in;
        logic [GRID_W-1:0] mag_in;
        logic [DSH_W-1:0]  dsh;
        if (k == 0) begin : g_first
            assign rem_in = r_mag;
            assign mag_in = r_mag;
        end else begin : g_next
            assign rem_in = r_mrem[k-1];
            assign mag_in = r_mmag[k-1];
        end
        assign dsh = DSH_W'(n) << B;
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_mrem[k] <= (DSH_W'(rem_in) >= dsh) ? rem_in - dsh[GRID_W-1:0] : rem_in;
                r_mmag[k] <= mag_in;
            end
        end
    end

    for (genvar j = 0; j < ANG_STEPS; j++) begin : g_ang
        logic [GRID_W-1:0]    rem_in;
        logic [ANG_STEPS-1:0] q_in;
        logic [GRID_W-1:0]    mag_in;
        logic [GRID_W:0]      rem2;
        logic                 ge;
        if (j == 0) begin : g_first
            assign rem_in = r_mrem[MOD_STEPS-1];
            assign q_in   = '0;
            assign mag_in = r_mmag[MOD_STEPS-1];
        end else begin : g_next
            assign rem_in = r_arem[j-1];
            assign q_in   = r_aq[j-1];
            assign mag_in = r_amag[j-1];
        end
        assign rem2 = {rem_in, 1'b0};
        assign ge   = rem2 >= {1'b0, n};
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_arem[j] <= ge ? GRID_W'(rem2 - {1'b0, n}) : GRID_W'(rem2);
                r_aq[j]   <= {q_in[ANG_STEPS-2:0], ge};
                r_amag[j] <= mag_in;
            end
        end
    end

    assign z_raw = r_aq[ANG_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_z    <= (z_raw > ANG_STEPS'(QUARTER_TURN)) ?
                      ANG_STEPS'(32'h8000_0000 - {1'b0, z_raw}) : z_raw;
            r_zmag <= r_amag[ANG_STEPS-1];
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [CX_W-1:0] x_in;
        logic signed [CX_W-1:0] y_in;
        logic signed [CZ_W-1:0] z_in;
        logic [GRID_W-1:0]      m_in;
        if (i == 0) begin : g_first
            assign x_in = CX_W'(CORDIC_GAIN_Q30);
            assign y_in = '0;
            assign z_in = CZ_W'(r_z);
            assign m_in = r_zmag;
        end else begin : g_next
            assign x_in = r_cx[i-1];
            assign y_in = r_cy[i-1];
            assign z_in = r_cz[i-1];
            assign m_in = r_cmag[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                if (!z_in[CZ_W-1]) begin
                    r_cx[i] <= x_in - (y_in >>> i);
                    r_cy[i] <= y_in + (x_in >>> i);
                    r_cz[i] <= z_in - CZ_W'(ATAN_TURN[i]);
                end else begin
                    r_cx[i] <= x_in + (y_in >>> i);
                    r_cy[i] <= y_in - (x_in >>> i);
                    r_cz[i] <= z_in + CZ_W'(ATAN_TURN[i]);
                end
                r_cmag[i] <= m_in;
            end
        end
    end

    assign y_last = r_cy[CORDIC_STEPS-1];

    always_comb begin
        if (y_last[CX_W-1]) begin
            s = '0;
        end else if (y_last > Y_MAX) begin
            s = ANG_STEPS'(QUARTER_TURN);
        end else begin
            s = y_last[ANG_STEPS-1:0];
        end
    end

    assign tprod = 63'(s) * 63'(INV_PI_Q32);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_t     <= tprod[32+T_W-1:32];
            r_nd    <= ND_W'(n) * ND_W'(i_step);
            r_m1mag <= r_cmag[CORDIC_STEPS-1];
            r_pplo  <= 61'(r_nd[31:0]) * 61'(r_t);
            r_pphi  <= 40'(r_nd[ND_W-1:32]) * 40'(r_t);
            r_pc    <= P_W'(r_m1mag) * P_W'(i_step);
        end
    end

    assign prod = 73'(r_pplo) + (73'(r_pphi) << 32);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p  <= i_mode ? r_pc : prod[72:30];
            r_hh <= (2*PH_W)'(r_p[P_W-1:PL_W]) * (2*PH_W)'(r_p[P_W-1:PL_W]);
            r_hl <= (PH_W+PL_W)'(r_p[P_W-1:PL_W]) * (PH_W+PL_W)'(r_p[PL_W-1:0]);
            r_ll <= (2*PL_W)'(r_p[PL_W-1:0]) * (2*PL_W)'(r_p[PL_W-1:0]);
        end
    end

    assign sq = (SQ_W'(r_hh) << (2*PL_W)) + (SQ_W'(r_hl) << (PL_W+1)) + SQ_W'(r_ll);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_term <= (|sq[SQ_W-1:TERM_W+16]) ? '1 : sq[TERM_W+15:16];
        end
    end

    assign o_term = r_term;

endmodule

### hw/rtl/pgks_quot.sv
// Bit-per-stage quotient of a value magnitude shifted up 32 bits over the
// coefficient magnitude, with sign restore and clipping. Uses pgks_pkg.
module pgks_quot (
    input  logic                        i_clk,
    input  logic                        i_adv,
    input  logic [pgks_pkg::VAL_W-1:0]  i_mag,
    input  logic                        i_neg,
    input  logic [pgks_pkg::TERM_W-1:0] i_c,
    output logic [pgks_pkg::VAL_W-1:0]  o_result,
    output logic                        o_clip
);
    import pgks_pkg::*;

    logic [TERM_W-1:0] r0_rem;
    logic [TERM_W-1:0] r0_c;
    logic              r0_ovf;
    logic              r0_zero;
    logic              r0_neg;

    logic [TERM_W-1:0] r_rem  [QUOT_STEPS];
    logic [TERM_W-1:0] r_c    [QUOT_STEPS];
    logic [VAL_W-1:0]  r_q    [QUOT_STEPS];
    logic              r_ovf  [QUOT_STEPS];
    logic              r_zero [QUOT_STEPS];
    logic              r_neg  [QUOT_STEPS];

    logic [VAL_W-1:0] q_last;
    logic [VAL_W-1:0] limit;
    logic [VAL_W-1:0] qc;
    logic             clip;
    logic [VAL_W-1:0] r_result;
    logic             r_clip;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r0_rem  <= TERM_W'(i_mag);
            r0_c    <= i_c;
            r0_ovf  <= TERM_W'(i_mag) >= i_c;
            r0_zero <= i_mag == '0;
            r0_neg  <= i_neg;
        end
    end

    for (genvar k = 0; k < QUOT_STEPS; k++) begin : g_step
        logic [TERM_W-1:0] rem_in;
        logic [TERM_W-1:0] c_in;
        logic [VAL_W-1:0]  q_in;
        logic              ovf_in;
        logic              zero_in;
        logic              neg_in;
        logic [TERM_W:0]   rem2;
        logic              ge;
        if (k == 0) begin : g_first
            assign rem_in  = r0_rem;
            assign c_in    = r0_c;
            assign q_in    = '0;
            assign ovf_in  = r0_ovf;
            assign zero_in = r0_zero;
            assign neg_in  = r0_neg;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign c_in    = r_c[k-1];
            assign q_in    = r_q[k-1];
            assign ovf_in  = r_ovf[k-1];
            assign zero_in = r_zero[k-1];
            assign neg_in  = r_neg[k-1];
        end
        assign rem2 = {rem_in, 1'b0};
        assign ge   = rem2 >= {1'b0, c_in};
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k]  <= ge ? TERM_W'(rem2 - {1'b0, c_in}) : TERM_W'(rem2);
                r_c[k]    <= c_in;
                r_q[k]    <= {q_in[VAL_W-2:0], ge};
                r_ovf[k]  <= ovf_in;
                r_zero[k] <= zero_in;
                r_neg[k]  <= neg_in;
            end
        end
    end

    assign q_last = r_q[QUOT_STEPS-1];
    assign limit  = r_neg[QUOT_STEPS-1] ? 32'h7FFF_FFFF : 32'h8000_0000;
    assign clip   = !r_zero[QUOT_STEPS-1] && (r_ovf[QUOT_STEPS-1] || (q_last > limit));
    assign qc     = clip ? limit : q_last;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (r_zero[QUOT_STEPS-1]) begin
                r_result <= '0;
            end else begin
                r_result <= r_neg[QUOT_STEPS-1] ? qc : VAL_W'(-qc);
            end
            r_clip <= clip;
        end
    end

    assign o_result = r_result;
    assign o_clip   = r_clip;

endmodule

### hw/rtl/poisson_green_kernel_scale_core.sv
// Top level of the Poisson Green kernel scaling block: register file, three
// axis term pipelines, coefficient sum, two quotient pipelines and output skid.
// Depends on pgks_pkg, pgks_regs, pgks_axis_term and pgks_quot.
//
// The block takes one k-space word per clock and returns one scaled word per
// clock while the output is not stalled. Each word passes through the stages
// that each resolve one bit or one step: the modulo and angle dividers and the
// CORDIC in each axis pipeline, then the registered coefficient sum and the
// 32-bit quotient dividers with their set-up and finishing stages, and finally
// the output register. A stalled output fills a one-word skid stage, after
// which the input stalls until the output drains. Configuration must be written
// only while no word is in flight; the block itself does not enforce this.
module poisson_green_kernel_scale_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  pgks_pkg::t_in               i_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output pgks_pkg::t_out              o_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pgks_pkg::ADDR_W-1:0] paddr,
    input  logic [pgks_pkg::DATA_W-1:0] pwdata,
    output logic [pgks_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import pgks_pkg::*;

    t_cfg cfg;
    logic adv;
    logic in_fire;
    t_tag in_tag;

    logic [TERM_W-1:0] term_x;
    logic [TERM_W-1:0] term_y;
    logic [TERM_W-1:0] term_z;

    logic [AXIS_LAT-1:0] r_av;
    t_tag                r_ad [AXIS_LAT];

    logic [TERM_W+1:0] csum;
    logic              r_sv;
    logic [TERM_W-1:0] r_sc;
    t_tag              r_stag;

    logic [QUOT_LAT-1:0] r_qv;
    logic [QUOT_LAT-1:0] r_qz;

    logic [VAL_W-1:0] res_real;
    logic [VAL_W-1:0] res_imag;
    logic             clip_real;
    logic             clip_imag;
    logic             pipe_valid;
    t_out             pipe_data;

    t_out r_out;
    logic r_out_valid;
    t_out r_skid;
    logic r_skid_valid;

    pgks_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign adv     = !r_skid_valid;
    assign o_stall = r_skid_valid;
    assign in_fire = i_valid && !r_skid_valid;

    always_comb begin
        in_tag.zero_mode = (i_data.wave_index_x == '0) && (i_data.wave_index_y == '0) &&
                           (i_data.wave_index_z == '0);
        in_tag.neg_real  = i_data.value_real[VAL_W-1];
        in_tag.neg_imag  = i_data.value_imag[VAL_W-1];
        in_tag.mag_real  = in_tag.neg_real ? VAL_W'(-i_data.value_real) : i_data.value_real;
        in_tag.mag_imag  = in_tag.neg_imag ? VAL_W'(-i_data.value_imag) : i_data.value_imag;
    end

    pgks_axis_term u_axis_x (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_mode (cfg.kernel_mode),
        .i_idx  (i_data.wave_index_x),
        .i_grid (cfg.grid_size_x),
        .i_step (cfg.wave_step_x),
        .o_term (term_x)
    );

    pgks_axis_term u_axis_y (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_mode (cfg.kernel_mode),
        .i_idx  (i_data.wave_index_y),
        .i_grid (cfg.grid_size_y),
        .i_step (cfg.wave_step_y),
        .o_term (term_y)
    );

    pgks_axis_term u_axis_z (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_mode (cfg.kernel_mode),
        .i_idx  (i_data.wave_index_z),
        .i_grid (cfg.grid_size_z),
        .i_step (cfg.wave_step_z),
        .o_term (term_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= '0;
        end else if (adv) begin
            r_av <= {r_av[AXIS_LAT-2:0], in_fire};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ad[0] <= in_tag;
            for (int k = 1; k < AXIS_LAT; k++) begin
                r_ad[k] <= r_ad[k-1];
            end
        end
    end

    // A dimensions value of zero or one keeps the first axis only.
    assign csum = (TERM_W+2)'(term_x) +
                  ((cfg.dimensions > 2'd1) ? (TERM_W+2)'(term_y) : '0) +
                  ((cfg.dimensions > 2'd2) ? (TERM_W+2)'(term_z) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (adv) begin
            r_sv <= r_av[AXIS_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sc   <= (|csum[TERM_W+1:TERM_W]) ? '1 : csum[TERM_W-1:0];
            r_stag <= r_ad[AXIS_LAT-1];
        end
    end

    pgks_quot u_quot_real (
        .i_clk    (i_clk),
        .i_adv    (adv),
        .i_mag    (r_stag.mag_real),
        .i_neg    (r_stag.neg_real),
        .i_c      (r_sc),
        .o_result (res_real),
        .o_clip   (clip_real)
    );

    pgks_quot u_quot_imag (
        .i_clk    (i_clk),
        .i_adv    (adv),
        .i_mag    (r_stag.mag_imag),
        .i_neg    (r_stag.neg_imag),
        .i_c      (r_sc),
        .o_result (res_imag),
        .o_clip   (clip_imag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= '0;
        end else if (adv) begin
            r_qv <= {r_qv[QUOT_LAT-2:0], r_sv};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_qz <= {r_qz[QUOT_LAT-2:0], r_stag.zero_mode};
        end
    end

    assign pipe_valid = r_qv[QUOT_LAT-1];

    always_comb begin
        if (r_qz[QUOT_LAT-1]) begin
            pipe_data = '0;
        end else begin
            pipe_data.result_real = res_real;
            pipe_data.result_imag = res_imag;
            pipe_data.saturated   = clip_real | clip_imag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid  <= r_skid_valid | pipe_valid;
            r_skid_valid <= 1'b0;
        end else if (pipe_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= r_skid_valid ? r_skid : pipe_data;
        end else if (!r_skid_valid) begin
            r_skid <= pipe_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

### test/tb_poisson_green_kernel_scale_core.sv
// Self-checking testbench for poisson_green_kernel_scale_core: directed points, then random
// k-space words under several register settings and idling patterns, checked against a predictor.
// Depends on pgks_pkg and the block's RTL.
module tb_poisson_green_kernel_scale_core;
    timeunit 1ns;
    timeprecision 1ps;
    import pgks_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int ITEMS_PER_PH = 225;
    localparam int NUM_PHASES   = 8;
    localparam int DRAIN_CYCLES = 150;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out        o_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic        pready;

    t_cfg        kernel_cfg;
    t_out        pending_results[$];
    int          mismatch_count = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    int          clipped_seen = 0;
    int          cycle_count = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;

    typedef struct {
        t_in  point;
        bit   known;
        t_out want;
    } t_directed;

    poisson_green_kernel_scale_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [63:0] mul_shift_sat(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] prod;
        logic [127:0] shifted;
        prod = {64'd0, a} * {64'd0, b};
        if ((prod >> (64 + s)) != 0)
            return '1;
        shifted = prod >> s;
        return shifted[63:0];
    endfunction

    function automatic longint sine_q30(longint angle);
        longint x;
        longint y;
        longint dxv;
        longint dyv;
        x = CORDIC_GAIN_Q30;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dxv = y >>> i;
            dyv = x >>> i;
            if (angle >= 0) begin
                x -= dxv; y += dyv; angle -= longint'(ATAN_TURN[i]);
            end else begin
                x += dxv; y -= dyv; angle += longint'(ATAN_TURN[i]);
            end
        end
        if (y < 0) y = 0;
        if (y > QUARTER_TURN) y = QUARTER_TURN;
        return y;
    endfunction

    function automatic logic [63:0] axis_green_term(logic [GRID_W-1:0] grid,
                                                     logic [STEP_W-1:0] step,
                                                     logic [IDX_W-1:0] idx);
        longint unsigned n;
        longint unsigned dk;
        longint unsigned kmag;
        longint unsigned r;
        longint angle;
        longint unsigned t;
        logic [63:0] p;
        n = grid;
        dk = step;
        if (n == 0) n = 1;
        if (n > MAX_GRID) n = MAX_GRID;
        kmag = (2 * idx > n) ? ((idx < n) ? n - idx : idx - n) : idx;
        if (!kernel_cfg.kernel_mode) begin
            r = kmag % n;
            angle = longint'((r << 31) / n);
            if (angle > QUARTER_TURN) angle = 2 * longint'(QUARTER_TURN) - angle;
            t = (longint'(sine_q30(angle)) * longint'(INV_PI_Q32)) >> 32;
            p = mul_shift_sat(n * dk, t, 30);
        end else begin
            p = kmag * dk;
        end
        return mul_shift_sat(p, p, 16);
    endfunction

    function automatic logic [31:0] scale_by_coeff(logic [31:0] v, logic [63:0] cmag,
                                                   ref bit clip);
        logic neg;
        logic [63:0] vmag;
        logic [63:0] q;
        logic [63:0] lim;
        neg = v[31];
        vmag = neg ? (64'h1_0000_0000 - v) : v;
        if (vmag == 0)
            return 32'd0;
        q = (cmag == 0) ? '1 : (vmag << 32) / cmag;
        lim = neg ? 64'h7FFF_FFFF : 64'h8000_0000;
        if (q > lim) begin
            q = lim;
            clip = 1'b1;
        end
        return neg ? q[31:0] : 32'(64'h1_0000_0000 - q);
    endfunction

    function automatic t_out predict_scaled(t_in w);
        t_out res;
        logic [63:0] cmag;
        logic [63:0] term;
        bit clip;
        res = '0;
        clip = 1'b0;
        if (w.wave_index_x == 0 && w.wave_index_y == 0 && w.wave_index_z == 0)
            return res;
        cmag = axis_green_term(kernel_cfg.grid_size_x, kernel_cfg.wave_step_x, w.wave_index_x);
        if (kernel_cfg.dimensions > 1) begin
            term = axis_green_term(kernel_cfg.grid_size_y, kernel_cfg.wave_step_y,
                                   w.wave_index_y);
            cmag = (cmag > ~term) ? '1 : cmag + term;
        end
        if (kernel_cfg.dimensions > 2) begin
            term = axis_green_term(kernel_cfg.grid_size_z, kernel_cfg.wave_step_z,
                                   w.wave_index_z);
            cmag = (cmag > ~term) ? '1 : cmag + term;
        end
        res.result_real = scale_by_coeff(w.value_real, cmag, clip);
        res.result_imag = scale_by_coeff(w.value_imag, cmag, clip);
        res.saturated = clip;
        return res;
    endfunction

    task automatic write_reg(logic [2:0] regnum, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({regnum, 2'b00});
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (regnum)
            REG_KERNEL_MODE: kernel_cfg.kernel_mode = value[0];
            REG_DIMENSIONS:  kernel_cfg.dimensions  = value[1:0];
            REG_GRID_X:      kernel_cfg.grid_size_x = value[GRID_W-1:0];
            REG_GRID_Y:      kernel_cfg.grid_size_y = value[GRID_W-1:0];
            REG_GRID_Z:      kernel_cfg.grid_size_z = value[GRID_W-1:0];
            REG_STEP_X:      kernel_cfg.wave_step_x = value;
            REG_STEP_Y:      kernel_cfg.wave_step_y = value;
            REG_STEP_Z:      kernel_cfg.wave_step_z = value;
            default: ;
        endcase
    endtask

    task automatic load_setting(t_cfg c);
        write_reg(REG_KERNEL_MODE, 32'(c.kernel_mode));
        write_reg(REG_DIMENSIONS, 32'(c.dimensions));
        write_reg(REG_GRID_X, 32'(c.grid_size_x));
        write_reg(REG_GRID_Y, 32'(c.grid_size_y));
        write_reg(REG_GRID_Z, 32'(c.grid_size_z));
        write_reg(REG_STEP_X, c.wave_step_x);
        write_reg(REG_STEP_Y, c.wave_step_y);
        write_reg(REG_STEP_Z, c.wave_step_z);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_word(t_in w, bit known, t_out want);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= w;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(known ? want : predict_scaled(w));
        words_sent++;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (pending_results.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [IDX_W-1:0] pick_index(logic [GRID_W-1:0] grid);
        int n;
        n = (grid == 0) ? 1 : ((grid > MAX_GRID) ? MAX_GRID : grid);
        case ($urandom_range(5))
            0: return '0;
            1: return IDX_W'($urandom_range(3));
            2: return IDX_W'((n / 2) + $urandom_range(2)) - 1'b1;
            3: return IDX_W'(n - 1 - $urandom_range(1));
            default: return IDX_W'($urandom_range(1023));
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return 32'(signed'($urandom_range(2) - 1));
            4: return 32'($urandom_range(32'h0003_0000)) ^ {32{$urandom_range(1) == 1}};
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with no expectation: %h", o_data);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                words_checked++;
                if (o_data.saturated) clipped_seen++;
                if (o_data.result_real !== want.result_real) begin
                    $error("result_real: expected %0d, got %0d",
                           want.result_real, o_data.result_real);
                    mismatch_count++;
                end
                if (o_data.result_imag !== want.result_imag) begin
                    $error("result_imag: expected %0d, got %0d",
                           want.result_imag, o_data.result_imag);
                    mismatch_count++;
                end
                if (o_data.saturated !== want.saturated) begin
                    $error("saturated: expected %0b, got %0b",
                           want.saturated, o_data.saturated);
                    mismatch_count++;
                end
            end
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_directed directed[$];
        t_cfg settings[NUM_PHASES];
        t_in w;
        t_out zero_out;

        zero_out = '0;
        kernel_cfg = '{kernel_mode: 1'b0, dimensions: 2'd3,
                       grid_size_x: 11'd1024, grid_size_y: 11'd1024, grid_size_z: 11'd1024,
                       wave_step_x: 32'd16777216, wave_step_y: 32'd16777216,
                       wave_step_z: 32'd16777216};

        settings[0] = kernel_cfg;
        settings[1] = '{1'b1, 2'd3, 11'd1024, 11'd1024, 11'd1024,
                        32'h0100_0000, 32'h0180_0000, 32'h0010_0000};
        settings[2] = '{1'b0, 2'd2, 11'd1, 11'd2, 11'd0,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        settings[3] = '{1'b1, 2'd1, 11'd2047, 11'd5, 11'd9, 32'd1, 32'd1, 32'd1};
        settings[4] = '{1'b0, 2'd0, 11'd7, 11'd100, 11'd2047,
                        $urandom, $urandom, $urandom};
        settings[5] = '{1'b0, 2'd3, 11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)),
                        11'($urandom_range(1, 1024)), 32'($urandom_range(1, 32'h0400_0000)),
                        32'($urandom_range(1, 32'h0400_0000)), $urandom | 32'd1};
        settings[6] = '{1'b1, 2'd2, 11'd1024, 11'd3, 11'd1024,
                        32'hFFFF_FFFF, 32'd1, 32'h8000_0000};
        settings[7] = '{1'b0, 2'd3, 11'd1024, 11'd1024, 11'd2, 32'd1, 32'd1, 32'd1};

        directed.push_back('{'{10'd0, 10'd0, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000}, 1, zero_out});
        directed.push_back('{'{10'd0, 10'd0, 10'd0, -32'sd1, 32'sd1}, 1, zero_out});
        directed.push_back('{'{10'd1, 10'd0, 10'd0, 32'd0, 32'd0}, 1, zero_out});
        directed.push_back('{'{10'd1023, 10'd1023, 10'd1023, 32'd0, 32'd0}, 1, zero_out});
        directed.push_back('{'{10'd1, 10'd0, 10'd0, 32'h0001_0000, 32'hFFFF_0000}, 0, zero_out});
        directed.push_back('{'{10'd1, 10'd0, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF}, 0, zero_out});
        directed.push_back('{'{10'd512, 10'd0, 10'd0, 32'h0001_0000, 32'h0000_0001}, 0, zero_out});
        directed.push_back('{'{10'd513, 10'd0, 10'd0, 32'h0123_4567, 32'hFEDC_BA98}, 0, zero_out});
        directed.push_back('{'{10'd1023, 10'd1023, 10'd1023,
                               32'h7FFF_FFFF, 32'h8000_0000}, 0, zero_out});
        directed.push_back('{'{10'd0, 10'd1, 10'd0, 32'h5555_5555, 32'hAAAA_AAAA}, 0, zero_out});
        directed.push_back('{'{10'd0, 10'd0, 10'd1, 32'hAAAA_AAAA, 32'h5555_5555}, 0, zero_out});
        directed.push_back('{'{10'd511, 10'd512, 10'd513, 32'hFFFF_FFFF, 32'd1}, 0, zero_out});
        directed.push_back('{'{10'd256, 10'd768, 10'd341, 32'h0000_FFFF, 32'hFFFF_0001}, 0,
                            zero_out});
        directed.push_back('{'{10'h155, 10'h2AA, 10'h3FF, 32'h8000_0001, 32'h0000_8000}, 0,
                            zero_out});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_word(directed[i].point, directed[i].known, directed[i].want);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            i_valid <= 1'b0;
            gap_pct = 0;
            wait_drained();
            if (ph != 0)
                load_setting(settings[ph]);
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 55; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 55; end
                default: begin gap_pct = 26; stall_pct = 26; end
            endcase
            for (int k = 0; k < ITEMS_PER_PH; k++) begin
                w.wave_index_x = pick_index(kernel_cfg.grid_size_x);
                w.wave_index_y = pick_index(kernel_cfg.grid_size_y);
                w.wave_index_z = pick_index(kernel_cfg.grid_size_z);
                w.value_real = pick_value();
                w.value_imag = pick_value();
                send_word(w, 0, zero_out);
            end
        end
        i_valid <= 1'b0;
        stall_pct = 0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatch_count++;
        end

        $display("Sent %0d words over %0d register settings, checked %0d results (%0d clipped).",
                 words_sent, NUM_PHASES, words_checked, clipped_seen);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/pgks_pkg.sv
hw/rtl/pgks_regs.sv
hw/rtl/pgks_axis_term.sv
hw/rtl/pgks_quot.sv
hw/rtl/poisson_green_kernel_scale_core.sv
test/tb_poisson_green_kernel_scale_core.sv
